// File: hdl/lpu_pkg.sv
`default_nettype none

package lpu_pkg;

    // Field widths
    localparam int BPP_W    = 3;
    localparam int FRAME_W  = 21;
    localparam int WORD_W   = 32;
    localparam int SLOT_W   = 7;
    localparam int COLOR_W  = 24;
    localparam int IDX_W    = 8;
    localparam int CNT_W    = 6;

    // Defaults
    localparam int DEF_PALETTE_ENTRIES  = 256;
    localparam int DEF_MAX_FRAME_PIXELS = 1048576;
    localparam int QUEUE_DEPTH          = 2;

    // Register indexes
    localparam logic REG_BPP   = 1'b0;
    localparam logic REG_FRAME = 1'b1;

    // Reset values
    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 21'd76800;

    // Depth codes
    localparam logic [BPP_W-1:0] BPP_1  = 3'd0;
    localparam logic [BPP_W-1:0] BPP_2  = 3'd1;
    localparam logic [BPP_W-1:0] BPP_4  = 3'd2;
    localparam logic [BPP_W-1:0] BPP_8  = 3'd3;
    localparam logic [BPP_W-1:0] BPP_16 = 3'd4;

    // Item kinds after classification
    typedef enum logic [1:0] {
        K_PAL,
        K_LUT,
        K_DIRECT,
        K_DROP
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [WORD_W-1:0]   word;
        logic [SLOT_W-1:0]   slot;
    } t_job;

    // RGB565 to RGB888 by bit replication, red in the low byte
    function automatic logic [COLOR_W-1:0] widen565(input logic [15:0] c);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = c[15:11];
        g = c[10:5];
        b = c[4:0];
        return {b, b[4:2], g, g[5:4], r, r[4:2]};
    endfunction

    // Pixel index mask per depth code
    function automatic logic [IDX_W-1:0] px_mask(input logic [BPP_W-1:0] bpp);
        logic [IDX_W-1:0] m;
        case (bpp)
            BPP_1:   m = 8'h01;
            BPP_2:   m = 8'h03;
            BPP_4:   m = 8'h0f;
            default: m = 8'hff;
        endcase
        return m;
    endfunction

    // Pixels per word for palette depths
    function automatic logic [CNT_W-1:0] px_count(input logic [BPP_W-1:0] bpp);
        logic [CNT_W-1:0] n;
        case (bpp)
            BPP_1:   n = 6'd32;
            BPP_2:   n = 6'd16;
            BPP_4:   n = 6'd8;
            default: n = 6'd4;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hdl/lpu_ram.sv
`default_nettype none

module lpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read returns old data on collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/lpu_fifo.sv
`default_nettype none

module lpu_fifo #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_rdata,
    input  wire logic             i_pop
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [PW:0]      r_cnt,  n_cnt;
    logic             do_push, do_pop;

    assign o_ready = (r_cnt != (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill level update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lpu_front.sv
`default_nettype none

module lpu_front
    import lpu_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    localparam int PAL_WORDS      = (PALETTE_ENTRIES + 1) / 2
) (
    input  wire logic              i_tvalid,
    output logic                   o_tready,
    input  wire logic              i_tuser,     // mode
    input  wire logic [WORD_W-1:0] i_word,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic [BPP_W-1:0]  i_bpp,
    input  wire logic              i_q_ready,
    output logic                   o_push,
    output t_job                   o_job
);

    t_kind kind;

    // Classify: palette write, palette pixels, direct pixels, or nothing to do
    always_comb begin
        if (!i_tuser) begin
            kind = ({1'b0, i_slot} < 8'(PAL_WORDS)) ? K_PAL : K_DROP;
        end else begin
            case (i_bpp)
                BPP_1, BPP_2, BPP_4, BPP_8: kind = K_LUT;
                BPP_16:                     kind = K_DIRECT;
                default:                    kind = K_DROP;
            endcase
        end
    end

    assign o_tready   = i_q_ready;
    assign o_push     = i_tvalid && i_q_ready && (kind != K_DROP);
    assign o_job.kind = kind;
    assign o_job.word = i_word;
    assign o_job.slot = i_slot;

endmodule

`default_nettype wire

// File: hdl/lpu_back.sv
`default_nettype none

module lpu_back
    import lpu_pkg::*;
#(
    parameter int PALETTE_ENTRIES  = DEF_PALETTE_ENTRIES,
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS,
    localparam int PAL_WORDS       = (PALETTE_ENTRIES + 1) / 2,
    localparam int PAW             = (PAL_WORDS > 1) ? $clog2(PAL_WORDS) : 1,
    localparam int CW              = $clog2(MAX_FRAME_PIXELS + 1),
    localparam int CMPW            = (CW > FRAME_W) ? CW : FRAME_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [BPP_W-1:0]   i_bpp,
    input  wire logic [FRAME_W-1:0] i_frame_pixels,
    input  wire logic               i_q_valid,
    input  wire t_job               i_q_job,
    output logic                    o_q_pop,
    output logic                    o_tvalid,
    input  wire logic               i_tready,
    output logic      [COLOR_W-1:0] o_color,
    output logic                    o_frame_end,
    output logic                    o_last
);

    localparam logic [IDX_W:0] ENTRIES_LIM = (IDX_W+1)'(PALETTE_ENTRIES);

    // Unpack stage
    logic              r_a_busy, n_a_busy;
    logic [WORD_W-1:0] r_a_word, n_a_word;
    logic [CNT_W-1:0]  r_a_cnt,  n_a_cnt;
    logic              r_a_direct, n_a_direct;
    // Palette read stage
    logic              r_b_valid;
    logic              r_b_direct;
    logic [15:0]       r_b_raw;
    logic              r_b_last;
    logic              r_b_zero;
    logic              r_b_half;
    // Output register
    logic               r_o_valid;
    logic [COLOR_W-1:0] r_o_color;
    logic               r_o_fe;
    logic               r_o_last;
    // Frame counter
    logic [CW-1:0]      r_pcnt, n_pcnt;

    logic               o_free, b_free, b_adv, issue, a_done, pop;
    logic [IDX_W-1:0]   idx;
    logic               oor;
    logic               ram_we, ram_re;
    logic [WORD_W-1:0]  ram_rdata;
    logic [15:0]        c565;
    logic [COLOR_W-1:0] b_color;
    logic [CW-1:0]      cnt_inc;
    logic               n_fe;

    // Stage handshakes
    assign o_free = !r_o_valid || i_tready;
    assign b_adv  = r_b_valid && o_free;
    assign b_free = !r_b_valid || o_free;
    assign issue  = r_a_busy && b_free;
    assign a_done = issue && (r_a_cnt == CNT_W'(1));
    assign pop    = i_q_valid && (!r_a_busy || a_done);
    assign o_q_pop = pop;

    // Current pixel index and range check
    assign idx = r_a_word[IDX_W-1:0] & px_mask(i_bpp);
    assign oor = ({1'b0, idx} >= ENTRIES_LIM);

    // Palette store: two entries per word
    assign ram_we = pop && (i_q_job.kind == K_PAL);
    assign ram_re = issue && !r_a_direct && !oor;

    lpu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PAL_WORDS)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_job.slot[PAW-1:0]),
        .i_wdata (i_q_job.word),
        .i_re    (ram_re),
        .i_raddr (idx[PAW:1]),
        .o_rdata (ram_rdata)
    );

    // Unpack stage next state
    always_comb begin
        n_a_busy   = r_a_busy;
        n_a_word   = r_a_word;
        n_a_cnt    = r_a_cnt;
        n_a_direct = r_a_direct;
        if (issue) begin
            n_a_busy = !a_done;
            n_a_cnt  = r_a_cnt - 1'b1;
            if (r_a_direct) begin
                n_a_word = r_a_word >> 16;
            end else begin
                case (i_bpp)
                    BPP_1:   n_a_word = r_a_word >> 1;
                    BPP_2:   n_a_word = r_a_word >> 2;
                    BPP_4:   n_a_word = r_a_word >> 4;
                    default: n_a_word = r_a_word >> 8;
                endcase
            end
        end
        if (pop && (i_q_job.kind == K_LUT)) begin
            n_a_busy   = 1'b1;
            n_a_word   = i_q_job.word;
            n_a_cnt    = px_count(i_bpp);
            n_a_direct = 1'b0;
        end else if (pop && (i_q_job.kind == K_DIRECT)) begin
            n_a_busy   = 1'b1;
            n_a_word   = i_q_job.word;
            n_a_cnt    = CNT_W'(2);
            n_a_direct = 1'b1;
        end
    end

    // Color from palette or direct value
    assign c565    = r_b_direct ? r_b_raw : (r_b_half ? ram_rdata[31:16] : ram_rdata[15:0]);
    assign b_color = r_b_zero ? '0 : widen565(c565);

    // Frame counter
    assign cnt_inc = r_pcnt + 1'b1;
    always_comb begin
        n_fe   = (CMPW'(cnt_inc) == CMPW'(i_frame_pixels));
        n_pcnt = r_pcnt;
        if (b_adv) begin
            if (n_fe || (cnt_inc >= CW'(MAX_FRAME_PIXELS))) begin
                n_pcnt = '0;
            end else begin
                n_pcnt = cnt_inc;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_busy  <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_pcnt    <= '0;
        end else begin
            r_a_busy <= n_a_busy;
            r_pcnt   <= n_pcnt;
            if (issue) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_a_word   <= n_a_word;
        r_a_cnt    <= n_a_cnt;
        r_a_direct <= n_a_direct;
        if (issue) begin
            r_b_direct <= r_a_direct;
            r_b_raw    <= r_a_word[15:0];
            r_b_last   <= (r_a_cnt == CNT_W'(1));
            r_b_zero   <= oor && !r_a_direct;
            r_b_half   <= idx[0];
        end
        if (b_adv) begin
            r_o_color <= b_color;
            r_o_fe    <= n_fe;
            r_o_last  <= r_b_last;
        end
    end

    assign o_tvalid    = r_o_valid;
    assign o_color     = r_o_color;
    assign o_frame_end = r_o_fe;
    assign o_last      = r_o_last;

    // Checks
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_busy |-> (r_a_cnt != '0))
        else $error("unpack stage busy with no pixels left");

    a_pcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt < CW'(MAX_FRAME_PIXELS))
        else $error("frame counter out of range");

    a_fe_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && n_fe) |=> (r_pcnt == '0))
        else $error("frame counter did not wrap at frame end");

    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !o_free) |=> $stable(ram_rdata))
        else $error("palette read data changed under stall");

endmodule

`default_nettype wire

// File: hdl/lcd_pixel_unpacker_unit.sv
`default_nettype none

// Palettized LCD pixel unpacker. Takes 32-bit frame-buffer words on the slave
// stream: tuser=0 writes two RGB565 palette entries (low half to entry
// 2*index), tuser=1 is a pixel word split LSB first at the depth in bpp_mode
// (1/2/4/8 bpp through the palette, 16 bpp as two direct RGB565 pixels).
// Each pixel leaves as RGB888 with tlast on the last pixel of its word and
// tuser on the pixel that completes a frame. A front classifier feeds a
// two-entry job queue; the back end emits one pixel per cycle while the
// master stream accepts, and a pixel word yields 32, 16, 8, 4 or 2 pixels
// (32 >> bpp_mode, or 2 at 16 bpp); the single palette read port and the
// one-pixel output register set that rate. Write bpp_mode (0x0) and
// frame_pixels (0x4) only while idle.
module lcd_pixel_unpacker_unit
    import lpu_pkg::*;
#(
    parameter int PALETTE_ENTRIES  = DEF_PALETTE_ENTRIES,
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // [31:0] data_word, [38:32] palette_word_index
    input  wire logic        i_s_axis_tuser,  // [0] mode
    // Master stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // [23:0] pixel_color
    output logic             o_m_axis_tuser,  // [0] frame_end
    output logic             o_m_axis_tlast,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [BPP_W-1:0]   r_bpp;
    logic [FRAME_W-1:0] r_frame;
    logic               cfg_wr;

    t_job               f_job;
    logic               f_push;
    logic               q_ready;
    logic               q_valid;
    logic               q_pop;
    logic [$bits(t_job)-1:0] q_rdata;
    t_job               q_job;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp   <= BPP_RESET;
            r_frame <= FRAME_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_BPP:   r_bpp   <= pwdata[BPP_W-1:0];
                REG_FRAME: r_frame <= pwdata[FRAME_W-1:0];
                default:   r_bpp   <= r_bpp;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BPP:   prdata = {{(32-BPP_W){1'b0}}, r_bpp};
            REG_FRAME: prdata = {{(32-FRAME_W){1'b0}}, r_frame};
            default:   prdata = '0;
        endcase
    end

    // Classifier
    lpu_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tuser   (i_s_axis_tuser),
        .i_word    (i_s_axis_tdata[31:0]),
        .i_slot    (i_s_axis_tdata[38:32]),
        .i_bpp     (r_bpp),
        .i_q_ready (q_ready),
        .o_push    (f_push),
        .o_job     (f_job)
    );

    // Job queue
    lpu_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata (f_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_rdata (q_rdata),
        .i_pop   (q_pop)
    );

    assign q_job = t_job'(q_rdata);

    // Unpack, palette lookup and output
    lpu_back #(
        .PALETTE_ENTRIES  (PALETTE_ENTRIES),
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bpp          (r_bpp),
        .i_frame_pixels (r_frame),
        .i_q_valid      (q_valid),
        .i_q_job        (q_job),
        .o_q_pop        (q_pop),
        .o_tvalid       (o_m_axis_tvalid),
        .i_tready       (i_m_axis_tready),
        .o_color        (o_m_axis_tdata),
        .o_frame_end    (o_m_axis_tuser),
        .o_last         (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
